// File: rtl/core/lpe_pkg.sv
// Package for the RGB LED pulse encoder: pixel and timing types, register
// indexes and small helper functions.
// Used by every module of the encoder; depends on nothing else.
package lpe_pkg;

  // Pixel layout and sequencing constants.
  localparam int BITS_PER_PIXEL = 24;
  localparam int BIT_CNT_W      = $clog2(BITS_PER_PIXEL);

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int DUR_W       = 16;
  localparam int SHORT_W     = 8;

  // Default depth of the pixel queue between front and back.
  localparam int PIXEL_QUEUE_DEPTH = 2;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW   = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_LATCH     = CFG_INDEX_W'(4);

  // Register reset values.
  localparam logic [SHORT_W-1:0] RST_ZERO_HIGH = SHORT_W'(6);
  localparam logic [SHORT_W-1:0] RST_ZERO_LOW  = SHORT_W'(13);
  localparam logic [SHORT_W-1:0] RST_ONE_HIGH  = SHORT_W'(12);
  localparam logic [SHORT_W-1:0] RST_ONE_LOW   = SHORT_W'(7);
  localparam logic [DUR_W-1:0]   RST_LATCH     = DUR_W'(960);

  // One pixel as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic       last_pixel;
  } pixel_t;

  // Current segment timing, with every value already forced to at least one.
  typedef struct packed {
    logic [SHORT_W-1:0] zero_high;
    logic [SHORT_W-1:0] zero_low;
    logic [SHORT_W-1:0] one_high;
    logic [SHORT_W-1:0] one_low;
    logic [DUR_W-1:0]   latch;
  } timing_t;

  // A duration of zero is taken as one.
  function automatic logic [SHORT_W-1:0] min_one_short(input logic [SHORT_W-1:0] v);
    return (v == '0) ? SHORT_W'(1) : v;
  endfunction

  function automatic logic [DUR_W-1:0] min_one_long(input logic [DUR_W-1:0] v);
    return (v == '0) ? DUR_W'(1) : v;
  endfunction

endpackage

// File: rtl/core/rgb_led_pulse_encoder.sv
// RGB LED pulse encoder. Each pixel pushed in (green, red, blue, last_pixel)
// comes out as 48 timed line segments, a high and a low for every bit in GRB
// order, MSB first, plus one low latch segment when last_pixel is set. The
// segment sequencer produces one segment per clock while the result side
// takes them, and back-to-back pixels leave no gap between their segments.
// From an idle block a pushed pixel passes the queue, the sequencer state and
// the output register before its first segment shows on the result ports. A pixel queue of
// QUEUE_DEPTH entries lets pushes go on while earlier pixels are still being
// sent. Timing registers hold cycle counts; a count written as zero acts as one.
// Depends on lpe_pkg, lpe_cfg_regs, lpe_front and lpe_back.
module rgb_led_pulse_encoder
  import lpe_pkg::*;
#(
  parameter int QUEUE_DEPTH = PIXEL_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             green,
  input  logic [7:0]             red,
  input  logic [7:0]             blue,
  input  logic                   last_pixel,
  output logic                   empty,
  input  logic                   pop,
  output logic                   line_level,
  output logic [DUR_W-1:0]       duration,
  output logic                   last_segment
);

  timing_t timing;
  pixel_t  pix_in;
  pixel_t  pix_q;
  logic    pix_valid;
  logic    pix_take;
  logic    out_valid;

  assign pix_in = '{green: green, red: red, blue: blue, last_pixel: last_pixel};
  assign empty  = !out_valid;

  // Timing registers.
  lpe_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .timing    (timing)
  );

  // Pixel intake and queue.
  lpe_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pix_in    (pix_in),
    .pix_valid (pix_valid),
    .pix_out   (pix_q),
    .pix_take  (pix_take)
  );

  // Segment sequencer and output register.
  lpe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .timing       (timing),
    .pix_valid    (pix_valid),
    .pix          (pix_q),
    .pix_take     (pix_take),
    .pop          (pop),
    .out_valid    (out_valid),
    .line_level   (line_level),
    .duration     (duration),
    .last_segment (last_segment)
  );

endmodule

// File: rtl/core/lpe_cfg_regs.sv
// Timing register file of the RGB LED pulse encoder.
// Depends on lpe_pkg for the register indexes, reset values and timing_t.
module lpe_cfg_regs
  import lpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output timing_t                timing
);

  // Writes store the value with zero clamped to one; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.zero_high <= RST_ZERO_HIGH;
      timing.zero_low  <= RST_ZERO_LOW;
      timing.one_high  <= RST_ONE_HIGH;
      timing.one_low   <= RST_ONE_LOW;
      timing.latch     <= RST_LATCH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZERO_HIGH: timing.zero_high <= min_one_short(cfg_wdata[SHORT_W-1:0]);
        REG_ZERO_LOW:  timing.zero_low  <= min_one_short(cfg_wdata[SHORT_W-1:0]);
        REG_ONE_HIGH:  timing.one_high  <= min_one_short(cfg_wdata[SHORT_W-1:0]);
        REG_ONE_LOW:   timing.one_low   <= min_one_short(cfg_wdata[SHORT_W-1:0]);
        REG_LATCH:     timing.latch     <= min_one_long(cfg_wdata[DUR_W-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/core/lpe_front.sv
// Front of the RGB LED pulse encoder: takes pixels in and holds them in a
// short queue until the segment sequencer asks for the next one.
// Depends on lpe_pkg for pixel_t.
module lpe_front
  import lpe_pkg::*;
#(
  parameter int DEPTH = PIXEL_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  pixel_t     pix_in,
  output logic       pix_valid,
  output pixel_t     pix_out,
  input  logic       pix_take
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pixel_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pix_valid = (count != '0);
  assign pix_out   = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pix_take && pix_valid;

  // Pixel storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= pix_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/lpe_back.sv
// Back of the RGB LED pulse encoder: walks the 24 pixel bits, MSB first, and
// produces one line segment per cycle into an output register while it can advance.
// Depends on lpe_pkg for pixel_t, timing_t and the sequencing constants.
module lpe_back
  import lpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  timing_t          timing,
  input  logic             pix_valid,
  input  pixel_t           pix,
  output logic             pix_take,
  input  logic             pop,
  output logic             out_valid,
  output logic             line_level,
  output logic [DUR_W-1:0] duration,
  output logic             last_segment
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HIGH  = 4'b0010,
    S_LOW   = 4'b0100,
    S_LATCH = 4'b1000
  } seq_state_t;

  seq_state_t                state;
  seq_state_t                state_next;
  logic [BITS_PER_PIXEL-1:0] word;
  logic [BITS_PER_PIXEL-1:0] word_next;
  logic [BIT_CNT_W-1:0]      bit_cnt;
  logic [BIT_CNT_W-1:0]      bit_cnt_next;
  logic                      latch;
  logic                      latch_next;

  logic                      advance;
  logic                      seg_valid;
  logic                      emit;
  logic                      cur_bit;
  logic                      finishing;
  logic                      seg_level;
  logic [DUR_W-1:0]          seg_dur;
  logic                      seg_last;

  // The output register moves when it is empty or its segment is taken.
  assign advance   = !out_valid || pop;
  assign seg_valid = (state != S_IDLE);
  assign emit      = seg_valid && advance;
  assign cur_bit   = word[BITS_PER_PIXEL-1];

  // The pixel's final segment frees the sequencer for the next pixel at once.
  assign finishing = emit && (((state == S_LOW) && (bit_cnt == '0) && !latch) ||
                              (state == S_LATCH));
  assign pix_take  = pix_valid && ((state == S_IDLE) || finishing);

  // Segment that the current state describes.
  always_comb begin
    seg_level = 1'b0;
    seg_dur   = DUR_W'(1);
    seg_last  = 1'b0;
    case (state)
      S_HIGH: begin
        seg_level = 1'b1;
        seg_dur   = DUR_W'(cur_bit ? timing.one_high : timing.zero_high);
      end
      S_LOW: begin
        seg_dur   = DUR_W'(cur_bit ? timing.one_low : timing.zero_low);
        seg_last  = (bit_cnt == '0) && !latch;
      end
      S_LATCH: begin
        seg_dur   = timing.latch;
        seg_last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_next   = state;
    word_next    = word;
    bit_cnt_next = bit_cnt;
    latch_next   = latch;
    case (state)
      S_IDLE: begin
      end
      S_HIGH: begin
        if (emit) begin
          state_next = S_LOW;
        end
      end
      S_LOW: begin
        if (emit) begin
          if (bit_cnt != '0) begin
            bit_cnt_next = bit_cnt - 1'b1;
            word_next    = {word[BITS_PER_PIXEL-2:0], 1'b0};
            state_next   = S_HIGH;
          end else if (latch) begin
            state_next = S_LATCH;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_LATCH: begin
        if (emit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // A pixel taken from the queue starts with the high half of its first bit.
    if (pix_take) begin
      state_next   = S_HIGH;
      word_next    = {pix.green, pix.red, pix.blue};
      bit_cnt_next = BIT_CNT_W'(BITS_PER_PIXEL - 1);
      latch_next   = pix.last_pixel;
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    word    <= word_next;
    bit_cnt <= bit_cnt_next;
    latch   <= latch_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      line_level   <= seg_level;
      duration     <= seg_dur;
      last_segment <= seg_last;
    end
  end

endmodule

// File: rtl/core/lpe_checker.sv
// Port-level checks for the RGB LED pulse encoder, bound to the top level.
// Depends on lpe_pkg for port widths.
module lpe_checker
  import lpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             full,
  input  logic             empty,
  input  logic             pop,
  input  logic             line_level,
  input  logic [DUR_W-1:0] duration,
  input  logic             last_segment
);

  // Reset leaves the pixel queue and the output register empty.
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // A pixel always ends on a low segment.
  a_last_is_low: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_segment) |-> !line_level)
    else $error("final segment of a pixel is high");

  // High segments come from the eight-bit timing registers and are never zero.
  a_high_dur: assert property (@(posedge clk) disable iff (rst)
    (!empty && line_level) |-> ((duration[DUR_W-1:SHORT_W] == '0) && (duration != '0)))
    else $error("high segment duration out of range");

  // A waiting segment holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(duration) && $stable(line_level)))
    else $error("waiting segment changed");

endmodule

bind rgb_led_pulse_encoder lpe_checker u_lpe_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .line_level   (line_level),
  .duration     (duration),
  .last_segment (last_segment)
);

// File: tb/tb_rgb_led_pulse_encoder.sv
// Self-checking testbench for rgb_led_pulse_encoder: pushes pixels through the
// queue interface and checks every timed line segment against a local predictor.
// Depends on lpe_pkg and the rgb_led_pulse_encoder RTL.
module tb_rgb_led_pulse_encoder;
  timeunit 1ns;
  timeprecision 1ps;
  import lpe_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 5;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 10;
  localparam int RANDOM_PHASES   = 5;
  localparam int PHASE_PIXELS    = 31;

  // One line segment as it leaves the encoder.
  typedef struct packed {
    logic             line_level;
    logic [DUR_W-1:0] duration;
    logic             last_segment;
  } segment_t;

  // Predicts the segments of each accepted pixel and checks them in order.
  class segment_scoreboard;
    localparam int MAX_PRINTED = 40;

    logic [SHORT_W-1:0] zero_high;
    logic [SHORT_W-1:0] zero_low;
    logic [SHORT_W-1:0] one_high;
    logic [SHORT_W-1:0] one_low;
    logic [DUR_W-1:0]   latch_len;
    segment_t           segments_due[$];
    int                 mismatches;
    int                 segments_seen;

    function new();
      zero_high     = RST_ZERO_HIGH;
      zero_low      = RST_ZERO_LOW;
      one_high      = RST_ONE_HIGH;
      one_low       = RST_ONE_LOW;
      latch_len     = RST_LATCH;
      mismatches    = 0;
      segments_seen = 0;
    endfunction

    // Short registers keep only their low byte; unknown indexes change nothing.
    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_ZERO_HIGH: zero_high = value[SHORT_W-1:0];
        REG_ZERO_LOW:  zero_low  = value[SHORT_W-1:0];
        REG_ONE_HIGH:  one_high  = value[SHORT_W-1:0];
        REG_ONE_LOW:   one_low   = value[SHORT_W-1:0];
        REG_LATCH:     latch_len = value[DUR_W-1:0];
        default: ;
      endcase
    endfunction

    // A programmed length of zero is still predicted as one.
    function void add_segment(logic level, logic [DUR_W-1:0] len, logic last);
      segment_t seg;
      seg.line_level   = level;
      seg.duration     = (len == '0) ? DUR_W'(1) : len;
      seg.last_segment = last;
      segments_due.push_back(seg);
    endfunction

    // GRB order, MSB first; a high and a low per bit, then the latch if marked.
    function void note_pixel(pixel_t px);
      logic [BITS_PER_PIXEL-1:0] bits;
      logic                      one;
      bits = {px.green, px.red, px.blue};
      for (int b = BITS_PER_PIXEL - 1; b >= 0; b--) begin
        one = bits[b];
        add_segment(1'b1, one ? DUR_W'(one_high) : DUR_W'(zero_high), 1'b0);
        add_segment(1'b0, one ? DUR_W'(one_low) : DUR_W'(zero_low),
                    (b == 0) && !px.last_pixel);
      end
      if (px.last_pixel) begin
        add_segment(1'b0, latch_len, 1'b1);
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
        $display("mismatch at %0t: %s", $time, msg);
      end
    endtask

    task check_segment(logic level, logic [DUR_W-1:0] len, logic last);
      segment_t want;
      if (segments_due.size() == 0) begin
        report_mismatch($sformatf("segment level %0d duration %0d last %0d with none expected",
                                  level, len, last));
        return;
      end
      want = segments_due.pop_front();
      if (level !== want.line_level) begin
        report_mismatch($sformatf("segment %0d line_level %0d, expected %0d",
                                  segments_seen, level, want.line_level));
      end
      if (len !== want.duration) begin
        report_mismatch($sformatf("segment %0d duration %0d, expected %0d",
                                  segments_seen, len, want.duration));
      end
      if (last !== want.last_segment) begin
        report_mismatch($sformatf("segment %0d last_segment %0d, expected %0d",
                                  segments_seen, last, want.last_segment));
      end
      segments_seen++;
    endtask

    function int pending();
      return segments_due.size();
    endfunction

    task check_drained();
      if (segments_due.size() != 0) begin
        report_mismatch($sformatf("%0d segments never arrived", segments_due.size()));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   push;
  logic                   full;
  logic [7:0]             green;
  logic [7:0]             red;
  logic [7:0]             blue;
  logic                   last_pixel;
  logic                   empty;
  logic                   pop;
  logic                   line_level;
  logic [DUR_W-1:0]       duration;
  logic                   last_segment;

  bit                     idle_enabled;
  int                     hold_off_request;
  segment_scoreboard      sb = new();

  rgb_led_pulse_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .green        (green),
    .red          (red),
    .blue         (blue),
    .last_pixel   (last_pixel),
    .empty        (empty),
    .pop          (pop),
    .line_level   (line_level),
    .duration     (duration),
    .last_segment (last_segment)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Offers one pixel until it is taken, sometimes after a short idle burst.
  task automatic send_pixel(logic [7:0] g, logic [7:0] r, logic [7:0] b, logic last);
    pixel_t px;
    px.green      = g;
    px.red        = r;
    px.blue       = b;
    px.last_pixel = last;
    if (idle_enabled && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    push       <= 1'b1;
    green      <= px.green;
    red        <= px.red;
    blue       <= px.blue;
    last_pixel <= px.last_pixel;
    do @(posedge clk); while (full);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  // Every pixel yields segments, so an empty prediction means the block is idle.
  task automatic settle_phase();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_one(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    sb.write_reg(index, value);
    @(negedge clk);
  endtask

  // Writes all five timing registers, then a stray write that must be ignored.
  task automatic apply_timing(logic [CFG_DATA_W-1:0] zh, logic [CFG_DATA_W-1:0] zl,
                              logic [CFG_DATA_W-1:0] oh, logic [CFG_DATA_W-1:0] ol,
                              logic [CFG_DATA_W-1:0] lt);
    write_one(REG_ZERO_HIGH, zh);
    write_one(REG_ZERO_LOW, zl);
    write_one(REG_ONE_HIGH, oh);
    write_one(REG_ONE_LOW, ol);
    write_one(REG_LATCH, lt);
    write_one(CFG_INDEX_W'($urandom_range(REG_LATCH + 1, (1 << CFG_INDEX_W) - 1)),
              CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Favors zero, all ones and tiny values alongside fully random data.
  function automatic logic [CFG_DATA_W-1:0] pick_duration();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'($urandom_range(1, 3));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Result side: pops with random idle bursts and one long hold-off on request.
  initial begin
    pop = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_off_request != 0) begin
        pop <= 1'b0;
        repeat (hold_off_request) @(negedge clk);
        hold_off_request = 0;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (pop && !empty) begin
        sb.check_segment(line_level, duration, last_segment);
      end
      @(negedge clk);
    end
  end

  // Ends the run if no item moves on either side for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    wait (rst === 1'b0);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence: reset, directed pixels, then random phases.
  initial begin
    rst              = 1'b1;
    push             = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    green            = '0;
    red              = '0;
    blue             = '0;
    last_pixel       = 1'b0;
    idle_enabled     = 1'b1;
    hold_off_request = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset timing: all-zero and all-one pixels, lone MSBs and LSBs, mixed bytes.
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'h80, 8'h80, 8'h80, 1'b0);
    send_pixel(8'h01, 8'h01, 8'h01, 1'b1);
    send_pixel(8'hAA, 8'h55, 8'hC3, 1'b0);
    send_pixel(8'h55, 8'hAA, 8'h3C, 1'b1);

    // Every timing register written as zero must act as one.
    settle_phase();
    apply_timing('0, '0, '0, '0, '0);
    send_pixel(8'hF0, 8'h0F, 8'h99, 1'b1);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);

    // Largest lengths: 255 for the bit halves and the full 16-bit latch.
    settle_phase();
    apply_timing('1, '1, '1, '1, '1);
    send_pixel(8'hC5, 8'h3A, 8'h81, 1'b1);
    send_pixel(8'h7E, 8'hE7, 8'h18, 1'b0);

    // Distinct small values catch swapped registers; upper bytes must be dropped.
    settle_phase();
    apply_timing(16'hAB01, 16'h5402, 16'h0003, 16'hFF04, 16'h0005);
    send_pixel(8'h96, 8'h69, 8'hF0, 1'b1);
    send_pixel(8'h0F, 8'hA5, 8'h5A, 1'b1);

    // Shortest nonzero lengths.
    settle_phase();
    apply_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    send_pixel(8'hFF, 8'h00, 8'hAA, 1'b0);
    send_pixel(8'h55, 8'hFF, 8'h00, 1'b1);

    // Random phases; the second one starts with a long hold-off on the result
    // side so the pixel queue fills, and the last one runs without idling.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_phase();
      apply_timing(pick_duration(), pick_duration(), pick_duration(), pick_duration(),
                   pick_duration());
      idle_enabled = (phase != RANDOM_PHASES - 1);
      if (phase == 1) begin
        hold_off_request = HOLD_OFF_CYCLES;
      end
      repeat (PHASE_PIXELS) begin
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
      end
    end

    // Drain, then give any stray segment time to show up.
    settle_phase();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
